### rtl/usb_ether_rx_deframer_defines.svh
// ----------------------------------------------------------------------------
// usb ether rx deframer assertion macros
// shared assertion forms for the deframer checkers
// ----------------------------------------------------------------------------
`ifndef USB_ETHER_RX_DEFRAMER_DEFINES_SVH
`define USB_ETHER_RX_DEFRAMER_DEFINES_SVH

// property checked on every clock outside reset
`define UERD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("uerd assertion failed");

// property checked in the cycle after reset is high
`define UERD_ASSERT_RESET(label, clk, rst, prop) \
   label: assert property (@(posedge clk) rst |=> prop) \
      else $error("uerd reset assertion failed");

`endif

### rtl/uerd_pkg.sv
// ----------------------------------------------------------------------------
// uerd_pkg
// status codes and constants of the usb ether rx deframer
// ----------------------------------------------------------------------------
package uerd_pkg;

   typedef logic [1:0] status_type;

   localparam status_type ST_BYTE   = 2'd0;
   localparam status_type ST_BADHDR = 2'd1;
   localparam status_type ST_CUT    = 2'd2;

   localparam logic [15:0] LEN_COMP     = 16'hFFFF;
   localparam logic [15:0] MIN_LEN      = 16'd6;
   localparam logic [15:0] MAX_PAY_INIT = 16'd1514;

endpackage

### rtl/usb_ether_rx_deframer.sv
// ----------------------------------------------------------------------------
// usb_ether_rx_deframer
// splits a bulk byte stream into frames with a length/complement header
// ----------------------------------------------------------------------------
// an accepted request is held in the input reg, then its result in the result reg
// throughput: one request per cycle, limited only by rsp_stall
// requests that give no result leave the result stage empty
// reset: synchronous, active high; header phase, max_payload back to 1514
// ----------------------------------------------------------------------------
module usb_ether_rx_deframer
   import uerd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_transfer_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DROP    = 2'd2;

   logic [15:0] max_payload_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_data_ff;
   logic        s1_end_ff;

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] hdr_ff, hdr_in;
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [15:0] flen_ff, flen_in;
   logic [15:0] pidx_ff, pidx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        advance;
   logic        accept;
   logic        emit;
   logic [16:0] pnext;
   logic [31:0] hd;
   logic [15:0] hlen;
   logic [15:0] hchk;

   // register port
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {16'd0, max_payload_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAY_INIT;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         max_payload_ff <= pwdata[15:0];
      end
   end

   // handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // one deframing step on the registered request
   assign pnext = {1'b0, pidx_ff} + 17'd1;
   assign hd    = {s1_data_ff, hdr_ff};
   assign hlen  = hd[15:0];
   assign hchk  = hd[31:16] ^ LEN_COMP;

   always_comb begin
      phase_in      = phase_ff;
      hdr_in        = hdr_ff;
      hcnt_in       = hcnt_ff;
      flen_in       = flen_ff;
      pidx_in       = pidx_ff;
      emit          = 1'b0;
      rsp_status_in = ST_BYTE;
      rsp_byte_in   = 8'd0;
      rsp_last_in   = 1'b0;
      case (phase_ff)
         PH_PAYLOAD: begin
            pidx_in = pnext[15:0];
            if (pnext >= {1'b0, flen_ff}) begin
               phase_in = PH_HEADER;
               if (pidx_ff < max_payload_ff) begin
                  emit        = 1'b1;
                  rsp_byte_in = s1_data_ff;
                  rsp_last_in = 1'b1;
               end
            end else if (s1_end_ff) begin
               phase_in      = PH_HEADER;
               emit          = 1'b1;
               rsp_status_in = ST_CUT;
            end else if (pidx_ff < max_payload_ff) begin
               emit        = 1'b1;
               rsp_byte_in = s1_data_ff;
               rsp_last_in = (pnext == {1'b0, max_payload_ff});
            end
         end
         PH_DROP: begin
            if (s1_end_ff) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            if (hcnt_ff != 2'd3) begin
               case (hcnt_ff)
                  2'd0:    hdr_in = {hdr_ff[23:8], s1_data_ff};
                  2'd1:    hdr_in = {hdr_ff[23:16], s1_data_ff, hdr_ff[7:0]};
                  default: hdr_in = {s1_data_ff, hdr_ff[15:0]};
               endcase
               hcnt_in = hcnt_ff + 2'd1;
               if (s1_end_ff) begin
                  hdr_in  = 24'd0;
                  hcnt_in = 2'd0;
               end
            end else begin
               hdr_in  = 24'd0;
               hcnt_in = 2'd0;
               if (hlen != hchk || hlen < MIN_LEN) begin
                  phase_in      = s1_end_ff ? PH_HEADER : PH_DROP;
                  emit          = 1'b1;
                  rsp_status_in = ST_BADHDR;
               end else begin
                  flen_in = hlen;
                  pidx_in = 16'd0;
                  if (s1_end_ff) begin
                     emit          = 1'b1;
                     rsp_status_in = ST_CUT;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = s1_valid_ff && emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HEADER;
         hdr_ff       <= 24'd0;
         hcnt_ff      <= 2'd0;
         flen_ff      <= 16'd0;
         pidx_ff      <= 16'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && advance) begin
            phase_ff <= phase_in;
            hdr_ff   <= hdr_in;
            hcnt_ff  <= hcnt_in;
            flen_ff  <= flen_in;
            pidx_ff  <= pidx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data_byte;
         s1_end_ff  <= req_transfer_end;
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

### rtl/uerd_checker.sv
// ----------------------------------------------------------------------------
// uerd_checker
// port level checks of the usb ether rx deframer
// ----------------------------------------------------------------------------
`include "usb_ether_rx_deframer_defines.svh"

module uerd_checker
   import uerd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   `UERD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_byte) && $stable(rsp_last_byte))
   `UERD_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid)
   `UERD_ASSERT(a_err_clean, clock, reset, rsp_valid && rsp_status != ST_BYTE |-> rsp_out_byte == 8'd0 && !rsp_last_byte)
   `UERD_ASSERT(a_status_code, clock, reset, rsp_valid |-> rsp_status == ST_BYTE || rsp_status == ST_BADHDR || rsp_status == ST_CUT)
   `UERD_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind usb_ether_rx_deframer uerd_checker u_uerd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);

### bench/uerd_deframe_checker.sv
// ----------------------------------------------------------------------------
// uerd_deframe_checker
// watches the request, result and register ports of the rx deframer, keeps
// its own copy of the header/payload state, predicts the result of every
// accepted request and compares each accepted result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uerd_deframe_checker
   import uerd_pkg::*;
#(
   parameter logic [2:0] MAX_PAY_ADDR = 3'd0
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_transfer_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_byte,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending,
   output int          result_count
);

   typedef enum logic [1:0] {HDR_PHASE, PAY_PHASE, DROP_PHASE} deframe_phase_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  data;
      logic        last;
   } rx_result_type;

   deframe_phase_type phase;
   logic [23:0]       hdr_bytes;
   logic [1:0]        hdr_count;
   logic [15:0]       frame_len;
   logic [15:0]       pay_index;
   logic [15:0]       max_payload;
   rx_result_type     rx_due_q[$];

   initial begin
      fail_count   = 0;
      pending      = 0;
      result_count = 0;
   end

   task automatic report(input string msg);
      if (fail_count < 100)
         $display("ERROR @%0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic rx_result_type rx_result(input status_type st, input logic [7:0] d,
                                               input logic l);
      rx_result_type r;
      r.status = st;
      r.data   = d;
      r.last   = l;
      return r;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic tend);
      logic [15:0] cur_index;
      logic [16:0] next_index;
      logic [31:0] hdr;
      logic [15:0] flen;
      if (phase == PAY_PHASE) begin
         cur_index  = pay_index;
         next_index = {1'b0, cur_index} + 17'd1;
         pay_index  = next_index[15:0];
         if (next_index >= {1'b0, frame_len}) begin
            phase = HDR_PHASE;
            if (cur_index < max_payload)
               rx_due_q.push_back(rx_result(ST_BYTE, b, 1'b1));
         end else if (tend) begin
            phase = HDR_PHASE;
            rx_due_q.push_back(rx_result(ST_CUT, 8'd0, 1'b0));
         end else if (cur_index < max_payload) begin
            rx_due_q.push_back(rx_result(ST_BYTE, b, next_index == {1'b0, max_payload}));
         end
      end else if (phase == DROP_PHASE) begin
         if (tend)
            phase = HDR_PHASE;
      end else begin
         phase = HDR_PHASE;
         if (hdr_count != 2'd3) begin
            hdr_bytes = hdr_bytes | ({16'd0, b} << (8 * hdr_count));
            hdr_count = hdr_count + 2'd1;
            if (tend) begin
               hdr_bytes = '0;
               hdr_count = '0;
            end
         end else begin
            hdr       = {b, hdr_bytes};
            flen      = hdr[15:0];
            hdr_bytes = '0;
            hdr_count = '0;
            if (flen != (hdr[31:16] ^ LEN_COMP) || flen < MIN_LEN) begin
               phase = tend ? HDR_PHASE : DROP_PHASE;
               rx_due_q.push_back(rx_result(ST_BADHDR, 8'd0, 1'b0));
            end else begin
               frame_len = flen;
               pay_index = '0;
               if (tend)
                  rx_due_q.push_back(rx_result(ST_CUT, 8'd0, 1'b0));
               else
                  phase = PAY_PHASE;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rx_result_type want;
      if (reset) begin
         phase       = HDR_PHASE;
         hdr_bytes   = '0;
         hdr_count   = '0;
         frame_len   = '0;
         pay_index   = '0;
         max_payload = MAX_PAY_INIT;
         rx_due_q.delete();
      end else begin
         if (psel && penable && pready && paddr == MAX_PAY_ADDR) begin
            if (pwrite)
               max_payload = pwdata[15:0];
            else if (prdata !== {16'd0, max_payload})
               report($sformatf("max_payload read %0h, want %0h", prdata, max_payload));
         end
         if (req_valid && !req_stall)
            deframe_byte(req_data_byte, req_transfer_end);
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (rx_due_q.size() == 0) begin
               report($sformatf("result with nothing due, status %0d", rsp_status));
            end else begin
               want = rx_due_q.pop_front();
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_out_byte !== want.data)
                  report($sformatf("out_byte %0h, want %0h", rsp_out_byte, want.data));
               if (rsp_last_byte !== want.last)
                  report($sformatf("last_byte %0b, want %0b", rsp_last_byte, want.last));
            end
         end
      end
      pending = rx_due_q.size();
   end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives framed bulk transfers into the rx deframer: a short directed set,
// then random transfers of good, corrupted and cut-short frames over several
// max_payload settings, with bursty requests, paced result stalls and one
// long result hold-off; checking is done in uerd_deframe_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import uerd_pkg::*;

   localparam logic [2:0] MAX_PAY_ADDR = 3'd0;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_ITEMS  = 80;
   localparam int NUM_PHASES   = 6;

   typedef enum int {RX_READY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pace_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_transfer_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int          fail_count;
   int          pending;
   int          result_count;

   rx_pace_type stall_mode = RX_READY;
   logic [2:0]  stall_tick = 3'd0;
   logic        hold_arm = 1'b0;
   logic        hold_rsp = 1'b0;
   int          cycle_count = 0;
   int          sent_count = 0;
   int          burst_left = 0;
   logic [7:0]  xfer_q[$];

   usb_ether_rx_deframer i_dut (.*);

   uerd_deframe_checker #(.MAX_PAY_ADDR(MAX_PAY_ADDR)) i_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      stall_tick <= stall_tick + 3'd1;
      if (reset)
         rsp_stall <= 1'b0;
      else case (stall_mode)
         RX_READY:  rsp_stall <= hold_rsp;
         RX_LIGHT:  rsp_stall <= hold_rsp | ($urandom_range(0, 3) == 0);
         RX_HEAVY:  rsp_stall <= hold_rsp | ($urandom_range(0, 3) != 0);
         default:   rsp_stall <= hold_rsp | (stall_tick < 3'd3);
      endcase
   end

   // long result hold-off while requests keep coming
   initial begin
      wait (hold_arm);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic push_byte(input logic [7:0] b, input logic tend);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_transfer_end <= tend;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_xfer();
      int i;
      for (i = 0; i < xfer_q.size(); i++)
         push_byte(xfer_q[i], i == xfer_q.size() - 1);
      xfer_q.delete();
   endtask

   task automatic add_header(input logic [15:0] len_field, input logic [15:0] chk_field);
      xfer_q.push_back(len_field[7:0]);
      xfer_q.push_back(len_field[15:8]);
      xfer_q.push_back(chk_field[7:0]);
      xfer_q.push_back(chk_field[15:8]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_transfer();
      logic [15:0] flen;
      logic [31:0] hdr;
      int nframes;
      int f;
      int cut;
      if ($urandom_range(0, 9) == 0) begin
         // noise
         repeat ($urandom_range(1, 12)) xfer_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         nframes = $urandom_range(1, 3);
         for (f = 0; f < nframes; f++) begin
            flen = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(25, 90))
                                                : 16'($urandom_range(6, 24));
            hdr = {~flen, flen};
            case ($urandom_range(0, 11))
               0: hdr = hdr ^ (32'd1 << $urandom_range(0, 31));
               1: begin
                  flen = 16'($urandom_range(0, 5));
                  hdr  = {~flen, flen};
               end
               default: ;
            endcase
            add_header(hdr[15:0], hdr[31:16]);
            if (hdr[31:16] != ~hdr[15:0] || hdr[15:0] < MIN_LEN) begin
               repeat ($urandom_range(0, 6)) xfer_q.push_back(8'($urandom_range(0, 255)));
               break;
            end
            repeat (hdr[15:0]) xfer_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, xfer_q.size());
         while (xfer_q.size() > cut) void'(xfer_q.pop_back());
      end
      send_xfer();
   endtask

   initial begin
      int p;
      int phase_start;
      logic [15:0] cap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, MAX_PAY_ADDR, 32'd0);

      // complete frame ending its transfer, payload extremes
      add_header(16'd6, ~16'd6);
      xfer_q.push_back(8'h00);
      xfer_q.push_back(8'hFF);
      xfer_q.push_back(8'h5A);
      xfer_q.push_back(8'hA5);
      xfer_q.push_back(8'h01);
      xfer_q.push_back(8'h80);
      send_xfer();
      // short header at transfer end
      xfer_q.push_back(8'h06);
      xfer_q.push_back(8'h00);
      send_xfer();
      // bad complement on the transfer's last byte
      add_header(16'd6, 16'h0000);
      send_xfer();
      // good header on the transfer's last byte
      add_header(16'd8, ~16'd8);
      send_xfer();
      // transfer ends inside a payload
      add_header(16'd7, ~16'd7);
      xfer_q.push_back(8'h33);
      xfer_q.push_back(8'hCC);
      send_xfer();
      settle();

      for (p = 0; p < NUM_PHASES; p++) begin
         stall_mode = rx_pace_type'(p % 4);
         if (p == 0) begin
            hold_arm = 1'b1;
         end else begin
            case (p)
               1:       cap = 16'd1;
               2:       cap = 16'hFFFF;
               3:       cap = 16'd0;
               4:       cap = 16'($urandom_range(2, 30));
               default: cap = 16'($urandom_range(1, 12));
            endcase
            csr_access(1'b1, MAX_PAY_ADDR, {16'd0, cap});
            csr_access(1'b0, MAX_PAY_ADDR, 32'd0);
         end
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_ITEMS) random_transfer();
         settle();
      end

      $display("sent %0d request bytes, checked %0d results", sent_count, result_count);
      $display("max_payload settings: reset value, 1, 65535, 0 and two random caps");
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### usb_ether_rx_deframer.f
+incdir+rtl
rtl/uerd_pkg.sv
rtl/usb_ether_rx_deframer.sv
rtl/uerd_checker.sv
bench/uerd_deframe_checker.sv
bench/tb_top.sv
